FILE: sv/mbrp_pkg.sv
// ----------------------------------------------------------------------------
// MBR partition table parser package
// Shared types, constants and codes for the parser core.
// ----------------------------------------------------------------------------
package mbrp_pkg;

  localparam int MAX_PARTITIONS = 16;
  localparam int SLOT_W         = $clog2(MAX_PARTITIONS + 1);
  localparam int POS_W          = 10;

  localparam logic [SLOT_W-1:0] SLOT_LIMIT  = SLOT_W'(MAX_PARTITIONS);
  localparam logic [POS_W-1:0]  ENTRY_START = 10'd446;
  localparam logic [POS_W-1:0]  SIG_START   = 10'd510;
  localparam logic [POS_W-1:0]  SECTOR_LAST = 10'd511;
  localparam logic [POS_W-1:0]  POS_MAX     = 10'd1023;
  localparam logic [7:0]        BOOT_MARK   = 8'h80;
  localparam logic [15:0]       SIG_VALUE   = 16'hAA55;
  localparam int                SECTOR_SHIFT = 9;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_SIG = 3'd1,
    ST_BAD_LEN = 3'd2,
    ST_FULL    = 3'd3,
    ST_RANGE   = 3'd4
  } scan_status_e;

  typedef enum logic [1:0] {
    STEP_SKIP,
    STEP_RECORD,
    STEP_DONE
  } step_e;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } ctrl_state_e;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [3:0]  device_index;
    logic [47:0] device_total_sectors;
  } in_item_t;

  typedef struct packed {
    logic        record_kind;
    logic [3:0]  slot_index;
    logic [2:0]  entry_number;
    logic [3:0]  disk_index;
    logic [7:0]  partition_type;
    logic        bootable;
    logic [31:0] first_lba;
    logic [31:0] sector_total;
    logic [40:0] byte_size;
    logic [2:0]  scan_status;
    logic [4:0]  table_count;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic       take;
    logic       step_en;
    logic [2:0] entry_idx;
  } cmd_t;

  typedef struct packed {
    step_e step;
    logic  out_free;
  } sts_t;

endpackage

FILE: sv/mbrp_in_if.sv
// ----------------------------------------------------------------------------
// Sector byte channel
// Valid/ready channel carrying one sector byte or a clear item per transfer.
// ----------------------------------------------------------------------------
interface mbrp_in_if;
  import mbrp_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/mbrp_out_if.sv
// ----------------------------------------------------------------------------
// Partition record channel
// Valid/ready channel carrying one partition record or done item per transfer.
// ----------------------------------------------------------------------------
interface mbrp_out_if;
  import mbrp_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/mbrp_ctrl.sv
// ----------------------------------------------------------------------------
// MBR parser controller
// Takes sector bytes while idle and steps the entry walk after the last byte.
// ----------------------------------------------------------------------------
module mbrp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  mbrp_pkg::sts_t sts_i,
  output mbrp_pkg::cmd_t cmd_o
);
  import mbrp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [2:0]  idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_op_i == OP_BYTE && in_last_i) begin
          state_d = S_WALK;
          idx_d   = 3'd0;
        end
      end
      S_WALK: begin
        if (sts_i.out_free) begin
          unique case (sts_i.step)
            STEP_SKIP, STEP_RECORD: idx_d = idx_q + 3'd1;
            STEP_DONE:              state_d = S_IDLE;
            default:                state_d = S_IDLE;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == S_IDLE);
    cmd_o.take       = (state_q == S_IDLE) && in_valid_i;
    cmd_o.step_en    = (state_q == S_WALK) && sts_i.out_free;
    cmd_o.entry_idx  = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 3'd4)
    else $error("entry index past the table");

endmodule

FILE: sv/mbrp_datapath.sv
// ----------------------------------------------------------------------------
// MBR parser datapath
// Byte position, entry field registers, slot count, walk decision and the
// output register.
// ----------------------------------------------------------------------------
module mbrp_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbrp_pkg::in_item_t  in_i,
  input  mbrp_pkg::cmd_t      cmd_i,
  output mbrp_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mbrp_pkg::out_item_t out_o
);
  import mbrp_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [7:0]        sig_low_q, sig_low_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [3:0]        dev_q, dev_d;
  logic [47:0]       sectors_q, sectors_d;
  logic              len_ok_q, len_ok_d;
  logic              sig_ok_q, sig_ok_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q;

  logic              boot_q [4];
  logic [7:0]        type_q [4];
  logic [31:0]       lba_q  [4];
  logic [31:0]       cnt_q  [4];

  logic              byte_take;
  logic              in_entry;
  logic [POS_W-1:0]  off;
  logic [1:0]        wr_e;
  logic [3:0]        wr_k;
  logic [1:0]        sel;
  logic [32:0]       end_sum;
  logic              full;
  logic              empty;
  logic              past_end;
  scan_status_e      done_status;
  step_e             step;
  logic [SLOT_W+4:0] slot_ext;
  out_item_t         rec_item;
  out_item_t         done_item;

  assign byte_take = cmd_i.take && (in_i.operation == OP_BYTE);
  assign in_entry  = (pos_q >= ENTRY_START) && (pos_q < SIG_START);
  assign off       = pos_q - ENTRY_START;
  assign wr_e      = off[5:4];
  assign wr_k      = off[3:0];

  always_ff @(posedge clk_i) begin
    if (byte_take && in_entry) begin
      if (wr_k == 4'd0) boot_q[wr_e] <= (in_i.data_byte == BOOT_MARK);
      if (wr_k == 4'd4) type_q[wr_e] <= in_i.data_byte;
      if (wr_k[3:2] == 2'b10) lba_q[wr_e][{wr_k[1:0], 3'b000} +: 8] <= in_i.data_byte;
      if (wr_k[3:2] == 2'b11) cnt_q[wr_e][{wr_k[1:0], 3'b000} +: 8] <= in_i.data_byte;
    end
  end

  assign sel      = cmd_i.entry_idx[1:0];
  assign end_sum  = {1'b0, lba_q[sel]} + {1'b0, cnt_q[sel]};
  assign full     = (slot_q >= SLOT_LIMIT);
  assign empty    = (type_q[sel] == 8'd0) || (cnt_q[sel] == 32'd0);
  assign past_end = ({15'd0, end_sum} > sectors_q);

  always_comb begin
    step        = STEP_DONE;
    done_status = ST_OK;
    priority if (!len_ok_q) begin
      done_status = ST_BAD_LEN;
    end else if (!sig_ok_q) begin
      done_status = ST_BAD_SIG;
    end else if (cmd_i.entry_idx[2]) begin
      done_status = ST_OK;
    end else if (full) begin
      done_status = ST_FULL;
    end else if (empty) begin
      step = STEP_SKIP;
    end else if (past_end) begin
      done_status = ST_RANGE;
    end else begin
      step = STEP_RECORD;
    end
  end

  assign slot_ext = {5'd0, slot_q};

  always_comb begin
    rec_item                  = '0;
    rec_item.record_kind      = KIND_RECORD;
    rec_item.slot_index       = slot_ext[3:0];
    rec_item.entry_number     = cmd_i.entry_idx + 3'd1;
    rec_item.disk_index       = dev_q;
    rec_item.partition_type   = type_q[sel];
    rec_item.bootable         = boot_q[sel];
    rec_item.first_lba        = lba_q[sel];
    rec_item.sector_total     = cnt_q[sel];
    rec_item.byte_size        = {cnt_q[sel], SECTOR_SHIFT'(0)};

    done_item                 = '0;
    done_item.record_kind     = KIND_DONE;
    done_item.disk_index      = dev_q;
    done_item.scan_status     = done_status;
    done_item.table_count     = slot_ext[4:0];
    done_item.last_result     = 1'b1;
  end

  assign sts_o.step     = step;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    pos_d       = pos_q;
    sig_low_d   = sig_low_q;
    slot_d      = slot_q;
    dev_d       = dev_q;
    sectors_d   = sectors_q;
    len_ok_d    = len_ok_q;
    sig_ok_d    = sig_ok_q;
    out_valid_d = out_valid_q;

    if (out_ready_i) out_valid_d = 1'b0;

    if (cmd_i.take) begin
      if (in_i.operation == OP_CLEAR) begin
        slot_d = '0;
        pos_d  = '0;
      end else begin
        if (pos_q == '0) begin
          dev_d     = in_i.device_index;
          sectors_d = in_i.device_total_sectors;
        end
        if (pos_q == SIG_START) sig_low_d = in_i.data_byte;
        if (in_i.last_byte) begin
          pos_d    = '0;
          len_ok_d = (pos_q == SECTOR_LAST);
          sig_ok_d = ({in_i.data_byte, sig_low_q} == SIG_VALUE);
        end else if (pos_q != POS_MAX) begin
          pos_d = pos_q + 10'd1;
        end
      end
    end

    if (cmd_i.step_en && step != STEP_SKIP) begin
      out_valid_d = 1'b1;
      if (step == STEP_RECORD) slot_d = slot_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sig_low_q   <= '0;
      slot_q      <= '0;
      dev_q       <= '0;
      sectors_q   <= '0;
      len_ok_q    <= 1'b0;
      sig_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sig_low_q   <= sig_low_d;
      slot_q      <= slot_d;
      dev_q       <= dev_d;
      sectors_q   <= sectors_d;
      len_ok_q    <= len_ok_d;
      sig_ok_q    <= sig_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_en && step == STEP_RECORD) out_q <= rec_item;
    else if (cmd_i.step_en && step == STEP_DONE) out_q <= done_item;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_LIMIT)
    else $error("slot count past the table size");

  a_record_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.record_kind == KIND_RECORD) |->
      (out_q.entry_number != 3'd0 && out_q.entry_number <= 3'd4))
    else $error("record with bad partition number");

  a_slot_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step_en && step == STEP_RECORD && !(cmd_i.take && in_i.operation == OP_CLEAR))
      |=> slot_q == $past(slot_q) + SLOT_W'(1))
    else $error("slot count did not advance on a record");

endmodule

FILE: sv/mbr_partition_table_parser_core.sv
// ----------------------------------------------------------------------------
// MBR partition table parser core
// Parses sector zero of a disk and reports its primary partitions.
// ----------------------------------------------------------------------------
// Sector bytes are taken one per cycle whenever no table walk runs. The byte
// marked last starts a walk over the four table entries, one entry per
// cycle while the output is free, via a single output register: a record
// for each accepted entry and a done item at the end. Input is held off
// during the walk. The done item may still wait for transfer while bytes
// of the next sector come in. Slot numbers run on across sectors until a
// clear item.
module mbr_partition_table_parser_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  mbrp_in_if.sink           in_i,
  mbrp_out_if.source        out_o
);
  import mbrp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mbrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.payload.operation),
    .in_last_i  (in_i.payload.last_byte),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mbrp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i.payload),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (out_o.payload)
  );

endmodule
